// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the prefix tree block.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, off while reset is high.
`define PT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication check, with the consequence checked in the cycle after the trigger.
`define PT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ptrie_pkg.sv -----
`default_nettype none

package ptrie_pkg;

  localparam int NODES    = 1024;
  localparam int ALPHABET = 26;

  localparam int NODE_W = $clog2(NODES);
  localparam int FREE_W = NODE_W + 1;
  localparam int SLOTS  = NODES * ALPHABET;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int MODE_W = 2;
  localparam int CODE_W = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] letter;
    logic              last;
  } req_beat_t;

  typedef struct packed {
    logic found;
    logic pool_full;
  } rsp_beat_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } child_req_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [NODE_W-1:0] addr;
    logic              wdata;
  } mark_req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FINISH,
    S_EMIT
  } ctrl_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptrie_ram.sv -----
`default_nettype none

// Single-port-write, single-port-read synchronous RAM, registered read data.
module ptrie_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptrie_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module ptrie_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output      logic                        req_stall,
  input  wire ptrie_pkg::req_beat_t        req,
  output      logic                        rsp_valid,
  input  wire logic                        rsp_stall,
  output      ptrie_pkg::rsp_beat_t        rsp,
  output      ptrie_pkg::child_req_t       child_req,
  input  wire logic [ptrie_pkg::NODE_W-1:0] child_rdata,
  output      ptrie_pkg::mark_req_t        mark_req,
  input  wire logic                        mark_rdata
);

  import ptrie_pkg::*;

  ctrl_state_t       state, state_next;
  logic [SLOT_W-1:0] clr_addr;
  logic [FREE_W-1:0] next_free;
  logic [NODE_W-1:0] cursor;
  logic              missed;
  logic [MODE_W-1:0] wmode;
  logic              at_start;
  logic [SLOT_W-1:0] slot;
  logic              last_q;

  logic              accept;
  logic [MODE_W-1:0] eff_mode;
  logic              eff_missed;
  logic [NODE_W-1:0] eff_cursor;
  logic              walk;
  logic [SLOT_W-1:0] slot_addr;
  logic              hit;
  logic              pool_empty;
  logic              alloc;
  logic              out_free;
  logic              clr_done;
  rsp_beat_t         rsp_next;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // word-start overrides of the carried word state
  assign eff_mode   = at_start ? req.mode : wmode;
  assign eff_missed = at_start ? 1'b0 : missed;
  assign eff_cursor = at_start ? '0 : cursor;
  assign walk       = !eff_missed && (req.letter < CODE_W'(ALPHABET));
  assign slot_addr  = SLOT_W'(eff_cursor) * SLOT_W'(ALPHABET) + SLOT_W'(req.letter);

  assign hit        = (child_rdata != '0);
  assign pool_empty = (next_free == FREE_W'(NODES));
  assign alloc      = !hit && (wmode == MODE_INSERT) && !pool_empty;

  assign out_free = !rsp_valid || !rsp_stall;
  assign clr_done = (clr_addr == SLOT_W'(SLOTS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (walk) state_next = S_WALK;
          else if (req.last) state_next = S_FINISH;
        end
      end
      S_WALK: begin
        state_next = last_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // memory requests
  always_comb begin
    child_req = '0;
    mark_req  = '0;
    case (state)
      S_CLEAR: begin
        child_req.we   = 1'b1;
        child_req.addr = clr_addr;
        mark_req.we    = (clr_addr < SLOT_W'(NODES));
        mark_req.addr  = clr_addr[NODE_W-1:0];
      end
      S_IDLE: begin
        child_req.re   = accept && walk;
        child_req.addr = slot_addr;
      end
      S_WALK: begin
        child_req.we    = alloc;
        child_req.addr  = slot;
        child_req.wdata = next_free[NODE_W-1:0];
      end
      S_FINISH: begin
        mark_req.re    = 1'b1;
        mark_req.we    = (wmode == MODE_INSERT) && !missed;
        mark_req.addr  = cursor;
        mark_req.wdata = 1'b1;
      end
      default: begin
        child_req = '0;
        mark_req  = '0;
      end
    endcase
  end

  // result of a finished word
  always_comb begin
    rsp_next = '0;
    case (wmode)
      MODE_INSERT: rsp_next.pool_full = missed;
      MODE_SEARCH: rsp_next.found     = !missed && mark_rdata;
      default:     rsp_next.found     = !missed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      next_free <= FREE_W'(1);
      cursor    <= '0;
      missed    <= 1'b0;
      wmode     <= MODE_INSERT;
      at_start  <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + SLOT_W'(1);

      // load a new result, or drop the one just taken
      if (state == S_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            wmode    <= eff_mode;
            missed   <= eff_missed;
            cursor   <= eff_cursor;
            at_start <= 1'b0;
          end
        end
        S_WALK: begin
          if (hit) begin
            cursor <= child_rdata;
          end else if (alloc) begin
            cursor    <= next_free[NODE_W-1:0];
            next_free <= next_free + FREE_W'(1);
          end else begin
            missed <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            cursor    <= '0;
            missed    <= 1'b0;
            at_start  <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      slot   <= slot_addr;
      last_q <= req.last;
    end
    if (state == S_EMIT && out_free) begin
      rsp <= rsp_next;
    end
  end

  `PT_ASSERT(a_free_bound, next_free <= FREE_W'(NODES), "node counter overran the pool")
  `PT_ASSERT(a_rsp_from_emit, $rose(rsp_valid) |-> $past(state == S_EMIT), "stray result")
  `PT_ASSERT_NEXT(a_alloc_step, state == S_WALK && alloc, next_free == $past(next_free) + FREE_W'(1), "no step")
  `PT_ASSERT(a_no_write_full, (state == S_WALK && child_req.we) |-> !pool_empty, "write on full pool")

endmodule

`default_nettype wire

// ----- rtl/core/prefix_trie_insert_lookup.sv -----
`default_nettype none

// Prefix tree of lower-case words, fed one letter per beat on req and giving
// one result beat on rsp for each word (on its last letter). The mode of a
// word's first beat (insert, whole-word search, prefix query; code 3 acts as
// prefix) holds for the whole word. Letter codes 26..31 do not move the walk,
// so a word of only such codes is the empty word (root node). After reset the
// block sweeps all 26624 child-link memory entries, one entry per cycle,
// before it takes the first beat. A letter that walks the tree passes
// through a walk state before the next beat is taken, since the child-link
// memory read feeds the next letter's address; a letter that walks nothing
// (null code, or word already missed) does not stall req. After the last
// letter the block does the word-end mark read/write, then loads the result
// register, waiting on rsp_stall. The pool holds 1024 nodes; an insert
// that needs more is dropped and reports pool_full.
module prefix_trie_insert_lookup (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output      logic                 req_stall,
  input  wire ptrie_pkg::req_beat_t req,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_stall,
  output      ptrie_pkg::rsp_beat_t rsp
);

  import ptrie_pkg::*;

  child_req_t        child_req;
  mark_req_t         mark_req;
  logic [NODE_W-1:0] child_rdata;
  logic              mark_rdata;

  // Walk sequencer: word state, node allocation, result register.
  ptrie_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .child_req   (child_req),
    .child_rdata (child_rdata),
    .mark_req    (mark_req),
    .mark_rdata  (mark_rdata)
  );

  // Child links: one row of ALPHABET entries per node, 0 means no child.
  ptrie_ram #(
    .DEPTH (SLOTS),
    .WIDTH (NODE_W)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_req.we),
    .re    (child_req.re),
    .addr  (child_req.addr),
    .wdata (child_req.wdata),
    .rdata (child_rdata)
  );

  // Word-end marks, one per node; cleared in the same sweep.
  ptrie_ram #(
    .DEPTH (NODES),
    .WIDTH (1)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_req.we),
    .re    (mark_req.re),
    .addr  (mark_req.addr),
    .wdata (mark_req.wdata),
    .rdata (mark_rdata)
  );

endmodule

`default_nettype wire
